@@ rtl/mtg_pkg.sv @@
package mtg_pkg;

  localparam int unsigned TwN = 624;
  localparam int unsigned TwM = 397;
  localparam int unsigned IdxW = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned ValueW = 53;
  localparam int unsigned AddrW = 3;

  localparam logic [31:0] InitMul = 32'd1812433253;
  localparam logic [31:0] InitSeed = 32'd19650218;
  localparam logic [31:0] MixMul1 = 32'd1664525;
  localparam logic [31:0] MixMul2 = 32'd1566083941;
  localparam logic [31:0] MatrixA = 32'h9908b0df;
  localparam logic [31:0] TemperB = 32'h9d2c5680;
  localparam logic [31:0] TemperC = 32'hefc60000;
  localparam logic [31:0] UpperMask = 32'h80000000;
  localparam logic [31:0] LowerMask = 32'h7fffffff;

  localparam logic [AddrW-1:0] RegSeed = 3'd0;

  typedef enum logic [1:0] {
    ACT_RAW    = 2'd0,
    ACT_BELOW  = 2'd1,
    ACT_FRAC   = 2'd2,
    ACT_RESEED = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BI_RD,
    ST_BI_WR,
    ST_A_RD,
    ST_A_WAIT,
    ST_A_MUL,
    ST_A_WR,
    ST_B_RD,
    ST_B_WAIT,
    ST_B_MUL,
    ST_B_WR,
    ST_FIX0,
    ST_FIX0_WR,
    ST_TOP,
    ST_G_RD0,
    ST_G_RD1,
    ST_G_RD2,
    ST_G_WR,
    ST_D_RD,
    ST_D_WAIT,
    ST_D_USE,
    ST_OUT
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    logic [31:0] y;
    y = (a & UpperMask) | (b & LowerMask);
    return c ^ (y >> 1) ^ (y[0] ? MatrixA : 32'd0);
  endfunction

  function automatic logic [5:0] bit_len(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/mtg_if.sv @@
interface mtg_req_if;
  import mtg_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [31:0] limit;
  modport source (output valid, action, limit, input ready);
  modport sink (input valid, action, limit, output ready);
endinterface

interface mtg_rsp_if;
  import mtg_pkg::*;
  logic valid;
  logic ready;
  logic [ValueW-1:0] value;
  logic error;
  modport source (output valid, value, error, input ready);
  modport sink (input valid, value, error, output ready);
endinterface

@@ rtl/mtg_ram.sv @@
module mtg_ram
  import mtg_pkg::*;
#(
  parameter int unsigned Depth = TwN,
  parameter int unsigned AW = IdxW
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mtg_cfg.sv @@
module mtg_cfg
  import mtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [63:0]      seed
);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (psel && penable && pwrite && paddr == RegSeed) begin
      seed <= pwdata;
    end
  end

  always_comb begin
    prdata = 64'd0;
    if (paddr == RegSeed) prdata = seed;
  end
endmodule

@@ rtl/mtg_core.sv @@
module mtg_core
  import mtg_pkg::*;
#(
  parameter int unsigned N = TwN,
  parameter int unsigned M = TwM
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       seed,
  mtg_req_if.sink           req,
  mtg_rsp_if.source         rsp
);
  localparam int unsigned AW = $clog2(N + 1);

  state_t state, state_next;
  logic [AW-1:0] ridx;
  logic [AW-1:0] i;
  logic [AW:0] cnt;
  logic j;
  logic klen2;
  logic pass2;
  logic seeded;
  logic [1:0] act;
  logic [31:0] lim;
  logic [5:0] sh;
  logic [31:0] prev, cur, far, prod, w1;
  logic first_frac;
  logic [ValueW-1:0] value;
  logic error;
  logic ovalid;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  mtg_ram #(.Depth(N), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] key_w;
  logic [31:0] tw;
  logic [31:0] rshift;
  logic [AW-1:0] inext;
  logic [AW-1:0] gfar;

  assign key_w = j ? seed[63:32] : seed[31:0];
  assign tw = temper(rdata);
  assign rshift = tw >> sh;
  assign inext = (i == AW'(N - 1)) ? AW'(1) : i + AW'(1);
  assign gfar = (i + AW'(M) >= AW'(N)) ? i + AW'(M) - AW'(N) : i + AW'(M);

  assign req.ready = (state == ST_IDLE) && !ovalid;
  assign rsp.valid = ovalid;
  assign rsp.value = value;
  assign rsp.error = error;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          if (action_t'(req.action) == ACT_RESEED) state_next = ST_BI_WR;
          else if (!seeded) state_next = ST_OUT;
          else if (action_t'(req.action) == ACT_BELOW && req.limit == 32'd0)
            state_next = ST_OUT;
          else state_next = ST_TOP;
        end
      end
      ST_BI_WR:   state_next = (i == AW'(N - 1)) ? ST_A_RD : ST_BI_WR;
      ST_A_RD:    state_next = ST_A_WAIT;
      ST_A_WAIT:  state_next = ST_A_MUL;
      ST_A_MUL:   state_next = ST_A_WR;
      ST_A_WR:    state_next = (cnt == (AW + 1)'(1)) ? ST_B_RD :
                               ((i == AW'(N - 1)) ? ST_FIX0 : ST_A_RD);
      ST_FIX0:    state_next = ST_FIX0_WR;
      ST_FIX0_WR: state_next = pass2 ? ST_B_RD : ST_A_RD;
      ST_B_RD:    state_next = ST_B_WAIT;
      ST_B_WAIT:  state_next = ST_B_MUL;
      ST_B_MUL:   state_next = ST_B_WR;
      ST_B_WR:    state_next = (cnt == (AW + 1)'(1)) ? ST_BI_RD :
                               ((i == AW'(N - 1)) ? ST_FIX0 : ST_B_RD);
      ST_BI_RD:   state_next = ST_OUT;
      ST_TOP:     state_next = (ridx >= AW'(N)) ? ST_G_RD0 : ST_D_RD;
      ST_G_RD0:   state_next = ST_G_RD1;
      ST_G_RD1:   state_next = ST_G_RD2;
      ST_G_RD2:   state_next = ST_G_WR;
      ST_G_WR:    state_next = (i == AW'(N - 1)) ? ST_D_RD : ST_G_RD0;
      ST_D_RD:    state_next = ST_D_WAIT;
      ST_D_WAIT:  state_next = ST_D_USE;
      ST_D_USE: begin
        state_next = ST_OUT;
        if (action_t'(act) == ACT_BELOW && rshift >= lim) state_next = ST_TOP;
        if (action_t'(act) == ACT_FRAC && first_frac) state_next = ST_TOP;
      end
      ST_OUT:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = i;
    wdata = cur;
    raddr = i;
    case (state)
      ST_BI_WR: begin
        we = 1'b1;
        wdata = (i == AW'(0)) ? InitSeed : cur;
      end
      ST_A_RD, ST_B_RD: raddr = i;
      ST_A_WR: begin
        we = 1'b1;
        wdata = (cur ^ prod) + key_w + {31'd0, j};
      end
      ST_B_WR: begin
        we = 1'b1;
        wdata = (cur ^ prod) - 32'(i);
      end
      ST_FIX0: raddr = AW'(N - 1);
      ST_FIX0_WR: begin
        we = 1'b1;
        waddr = AW'(0);
        wdata = rdata;
      end
      ST_BI_RD: begin
        we = 1'b1;
        waddr = AW'(0);
        wdata = UpperMask;
      end
      ST_G_RD0: raddr = i;
      ST_G_RD1: raddr = (i == AW'(N - 1)) ? AW'(0) : i + AW'(1);
      ST_G_RD2: raddr = gfar;
      ST_G_WR: begin
        we = 1'b1;
        wdata = twist(cur, prev, rdata);
      end
      ST_D_RD, ST_D_WAIT: raddr = ridx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ridx <= AW'(N);
      seeded <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready) ovalid <= 1'b0;
      if (state == ST_OUT) ovalid <= 1'b1;
      if (state == ST_BI_RD) begin
        seeded <= 1'b1;
        ridx <= AW'(N);
      end
      if (state == ST_G_WR && i == AW'(N - 1)) ridx <= AW'(0);
      if (state == ST_D_USE) ridx <= ridx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          act <= req.action;
          lim <= req.limit;
          sh <= 6'd32 - bit_len(req.limit);
          first_frac <= 1'b1;
          value <= '0;
          error <= (action_t'(req.action) != ACT_RESEED) && !seeded;
          i <= AW'(0);
          j <= 1'b0;
          pass2 <= 1'b0;
          klen2 <= seed[63:32] != 32'd0;
          cur <= InitSeed;
        end
      end
      ST_BI_WR: begin
        // cur holds word i; build next
        cur <= InitMul * (cur ^ (cur >> 30)) + 32'(i + AW'(1));
        prev <= cur;
        i <= i + AW'(1);
        if (i == AW'(N - 1)) begin
          i <= AW'(1);
          cnt <= (AW + 1)'(N);
          prev <= InitSeed;
        end
      end
      ST_A_RD, ST_B_RD: ;
      ST_A_WAIT, ST_B_WAIT: cur <= rdata;
      ST_A_MUL: prod <= (prev ^ (prev >> 30)) * MixMul1;
      ST_B_MUL: prod <= (prev ^ (prev >> 30)) * MixMul2;
      ST_A_WR: begin
        prev <= (cur ^ prod) + key_w + {31'd0, j};
        i <= inext;
        j <= klen2 ? ~j : 1'b0;
        cnt <= cnt - (AW + 1)'(1);
        if (cnt == (AW + 1)'(1)) begin
          cnt <= (AW + 1)'(N - 1);
          pass2 <= 1'b1;
        end
      end
      ST_B_WR: begin
        prev <= (cur ^ prod) - 32'(i);
        i <= inext;
        cnt <= cnt - (AW + 1)'(1);
      end
      ST_FIX0: ;
      ST_FIX0_WR: ;
      ST_TOP: i <= AW'(0);
      ST_G_RD0: ;
      ST_G_RD1: cur <= rdata;
      ST_G_RD2: prev <= rdata;
      ST_G_WR: i <= i + AW'(1);
      ST_D_USE: begin
        case (action_t'(act))
          ACT_RAW: value <= ValueW'(tw);
          ACT_BELOW: value <= ValueW'(rshift);
          default: begin
            if (first_frac) w1 <= tw;
            else value <= {w1[31:5], tw[31:6]};
            first_frac <= 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/mersenne_twister_generator.sv @@
// channel | dir | payload
// req     | in  | action[1:0], limit[31:0]
// rsp     | out | value[52:0], error
// cfg     | in  | seed_value (64-bit APB register at 0)
// Raw word: index check, read, tempering, output; more draws repeat them.
// A state refill before a draw takes three reads per word written.
// Reseed: 624 init writes, 1247 mixing steps, one state read per step.
// Reset clears control; state memory is undefined until first reseed.
// A held result blocks the next request until it is taken.
module mersenne_twister_generator
  import mtg_pkg::*;
#(
  parameter int unsigned N = TwN,
  parameter int unsigned M = TwM
) (
  input  logic             clk,
  input  logic             rst,
  mtg_req_if.sink          req,
  mtg_rsp_if.source        rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  logic [63:0] seed;

  mtg_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .seed(seed)
  );

  mtg_core #(.N(N), .M(M)) u_core (
    .clk(clk), .rst(rst), .seed(seed), .req(req), .rsp(rsp)
  );
endmodule

@@ rtl/mtg_checker.sv @@
module mtg_assert (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_error,
  input logic [52:0] rsp_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("rsp dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_error |-> rsp_value == 53'd0)
    else $error("error with value");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("accept while busy");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after take");
endmodule

bind mersenne_twister_generator mtg_assert u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_error(rsp.error),
  .rsp_value(rsp.value)
);

@@ verif/mtg_checker.sv @@
`timescale 1ns / 100ps

module mtg_checker
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mtg_req_if          req_mon,
  mtg_rsp_if          rsp_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              error;
  } mt_result_t;

  logic [31:0] tw_state [TwN];
  int unsigned tw_index;
  logic        seeded;
  logic [63:0] seed_reg;
  mt_result_t  expected_results [$];
  mt_result_t  exp_r;
  mt_result_t  got_r;

  function automatic logic [31:0] chain_step(input logic [31:0] x);
    return x ^ (x >> 30);
  endfunction

  task automatic rebuild_state(input logic [63:0] sv);
    logic [31:0] key [2];
    int unsigned klen;
    int unsigned i;
    int unsigned j;
    key[0] = sv[31:0];
    key[1] = sv[63:32];
    klen = (key[1] != 0) ? 2 : 1;
    tw_state[0] = InitSeed;
    for (int n = 1; n < TwN; n++) begin
      tw_state[n] = 32'd1812433253 * chain_step(tw_state[n-1]) + 32'(n);
    end
    i = 1;
    j = 0;
    for (int n = 0; n < TwN; n++) begin
      tw_state[i] = (tw_state[i] ^ (chain_step(tw_state[i-1]) * 32'd1664525)) + key[j] + 32'(j);
      i++;
      j++;
      if (i >= TwN) begin
        tw_state[0] = tw_state[TwN-1];
        i = 1;
      end
      if (j >= klen) j = 0;
    end
    for (int n = 0; n < TwN - 1; n++) begin
      tw_state[i] = (tw_state[i] ^ (chain_step(tw_state[i-1]) * 32'd1566083941)) - 32'(i);
      i++;
      if (i >= TwN) begin
        tw_state[0] = tw_state[TwN-1];
        i = 1;
      end
    end
    tw_state[0] = 32'h80000000;
    tw_index = TwN;
    seeded = 1'b1;
  endtask

  function automatic logic [31:0] mix3(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return c ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'd0);
  endfunction

  task automatic refill_state();
    for (int n = 0; n < TwN - 1; n++) begin
      tw_state[n] = mix3(tw_state[n], tw_state[n+1], tw_state[(n + TwM) % TwN]);
    end
    tw_state[TwN-1] = mix3(tw_state[TwN-1], tw_state[0], tw_state[TwM-1]);
    tw_index = 0;
  endtask

  task automatic draw_word(output logic [31:0] w);
    logic [31:0] y;
    if (tw_index >= TwN) refill_state();
    y = tw_state[tw_index];
    tw_index++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    w = y;
  endtask

  task automatic draw_below(input logic [31:0] lim, output logic [31:0] r);
    int unsigned nbits;
    logic [31:0] w;
    nbits = 0;
    for (int b = 0; b < 32; b++) begin
      if (lim[b]) nbits = b + 1;
    end
    r = 32'd0;
    if (lim != 0) begin
      do begin
        draw_word(w);
        r = w >> (32 - nbits);
      end while (r >= lim);
    end
  endtask

  task automatic predict(input logic [1:0] act, input logic [31:0] lim);
    mt_result_t res;
    logic [31:0] w1;
    logic [31:0] w2;
    res = '0;
    if (act == ACT_RESEED) begin
      rebuild_state(seed_reg);
    end else if (!seeded) begin
      res.error = 1'b1;
    end else if (act == ACT_RAW) begin
      draw_word(w1);
      res.value = ValueW'(w1);
    end else if (act == ACT_BELOW) begin
      draw_below(lim, w1);
      res.value = ValueW'(w1);
    end else begin
      draw_word(w1);
      draw_word(w2);
      res.value = {w1[31:5], w2[31:6]};
    end
    expected_results = {expected_results, res};
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      tw_index = TwN;
      seeded = 1'b0;
      seed_reg = 64'd0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegSeed) seed_reg = pwdata;
      if (req_mon.valid && req_mon.ready) predict(req_mon.action, req_mon.limit);
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_r.value = rsp_mon.value;
        got_r.error = rsp_mon.error;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word value=%h error=%b", $realtime, got_r.value,
                     got_r.error);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value !== got_r.value || exp_r.error !== got_r.error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch value exp=%h got=%h error exp=%b got=%b", $realtime,
                       exp_r.value, got_r.value, exp_r.error, got_r.error);
          end
        end
      end
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import mtg_pkg::*;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  int n_items;
  int n_reseeds;
  logic rsp_stall_off = 1'b0;

  mtg_req_if req_ch ();
  mtg_rsp_if rsp_ch ();

  mersenne_twister_generator DUT (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mtg_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req_ch), .rsp_mon(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      int gap;
      gap = rsp_stall_off ? 0 : pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_word(input action_t act, input logic [31:0] lim, input bit no_gap);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.limit <= lim;
    do @(posedge clk); while (!req_ch.ready);
    n_items++;
    if (act == ACT_RESEED) n_reseeds++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] sv);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegSeed;
    pwdata <= sv;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFFFFFF;
    if (r == 2) return 32'h80000000 | 32'($urandom_range(0, 3));
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic action_t rand_action();
    int r;
    r = $urandom_range(0, 199);
    if (r < 2) return ACT_RESEED;
    if (r < 80) return ACT_RAW;
    if (r < 150) return ACT_BELOW;
    return ACT_FRAC;
  endfunction

  initial begin
    logic [63:0] seeds [6];
    bit calm;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_RAW;
    req_ch.limit = '0;
    rsp_stall_off = 1'b0;
    n_items = 0;
    n_reseeds = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(ACT_RAW, 32'hFFFFFFFF, 0);
    send_word(ACT_BELOW, 32'd7, 0);
    send_word(ACT_FRAC, 32'd0, 0);
    send_word(ACT_RESEED, 32'h5A5A5A5A, 0);
    send_word(ACT_RAW, 32'd0, 0);
    send_word(ACT_BELOW, 32'd0, 0);
    send_word(ACT_BELOW, 32'd1, 0);
    send_word(ACT_BELOW, 32'hFFFFFFFF, 0);
    send_word(ACT_BELOW, 32'h80000000, 0);
    send_word(ACT_BELOW, 32'h80000001, 0);
    send_word(ACT_FRAC, 32'hFFFFFFFF, 0);
    drain();
    write_seed(64'd1);
    send_word(ACT_RESEED, 32'd0, 1);
    send_word(ACT_RAW, 32'd0, 1);
    send_word(ACT_FRAC, 32'd0, 1);
    drain();
    write_seed(64'hFFFFFFFFFFFFFFFF);
    send_word(ACT_RESEED, 32'd0, 0);
    send_word(ACT_RAW, 32'd0, 0);
    send_word(ACT_BELOW, 32'd3, 0);
    drain();

    seeds[0] = 64'd0;
    seeds[1] = 64'h00000000FFFFFFFF;
    seeds[2] = 64'h0000000100000000;
    seeds[3] = {$urandom, $urandom};
    seeds[4] = 64'(unsigned'($urandom));
    seeds[5] = 64'hFFFFFFFFFFFFFFFF;
    foreach (seeds[p]) begin
      calm = (p == 2);
      rsp_stall_off = calm;
      write_seed(seeds[p]);
      send_word(ACT_RESEED, $urandom, calm);
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(0, 7) == 0) calm = ~calm;
        send_word(rand_action(), rand_limit(), calm);
      end
      drain();
    end
    rsp_stall_off = 1'b0;

    repeat (50) @(posedge clk);
    $display("Sent %0d requests including %0d reseeds over nine seed settings,",
             n_items, n_reseeds);
    $display("covering raw, bounded and fraction draws with random stalls on both sides.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule
